// ----- rtl/percent_reversal_trend_tracker_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the percent reversal trend tracker.
// Each macro expands to a clocked concurrent assertion that is gated by the
// active-low reset. In synthesis builds each macro expands to nothing.
// ---------------------------------------------------------------------------
`ifndef PERCENT_REVERSAL_TREND_TRACKER_CORE_ASSERT_SVH
`define PERCENT_REVERSAL_TREND_TRACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons holds too.
`define PRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define PRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define PRT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/prt_pkg.sv -----
// ---------------------------------------------------------------------------
// prt_pkg
// Shared types and constants of the percent reversal trend tracker.
// ---------------------------------------------------------------------------
package prt_pkg;

  // Width of the sample fields on the input channel.
  localparam int unsigned INPUT_BITS       = 32;
  // Default width at which samples are tracked.
  localparam int unsigned SAMPLE_BITS_DEF  = 32;
  // Threshold registers: unsigned Q8.8 percent.
  localparam int unsigned THRESH_BITS      = 16;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd256;
  // Percent scale: 100 percent times the Q8.8 fraction scale of 256.
  localparam int unsigned PCT_SCALE        = 25600;
  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH      = 2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS     = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FIRST_THRESHOLD  = 2'd0,
    CFG_SECOND_THRESHOLD = 2'd1,
    CFG_CLOSER_THRESHOLD = 2'd2
  } cfg_idx_t;

  // Tracker direction codes.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic valid;   // queue holds an item
    logic pop;     // back end consumes the head item this cycle
  } queue_ctl_t;

endpackage

// ----- rtl/prt_in_if.sv -----
// ---------------------------------------------------------------------------
// prt_in_if
// Input channel: two moving-average samples per item.
// ---------------------------------------------------------------------------
interface prt_in_if
  import prt_pkg::*;
();

  logic                  valid;
  logic                  ready;
  logic [INPUT_BITS-1:0] first_average;
  logic [INPUT_BITS-1:0] second_average;

  modport source (output valid, output first_average, output second_average,
                  input ready);
  modport sink   (input valid, input first_average, input second_average,
                  output ready);
endinterface

// ----- rtl/prt_out_if.sv -----
// ---------------------------------------------------------------------------
// prt_out_if
// Result channel: the three tracker directions and their summary bit.
// ---------------------------------------------------------------------------
interface prt_out_if;
  logic       valid;
  logic       ready;
  logic       all_decided;
  logic [1:0] first_direction;
  logic [1:0] second_direction;
  logic [1:0] closer_direction;

  modport source (output valid, output all_decided, output first_direction,
                  output second_direction, output closer_direction,
                  input ready);
  modport sink   (input valid, input all_decided, input first_direction,
                  input second_direction, input closer_direction,
                  output ready);
endinterface

// ----- rtl/percent_reversal_trend_tracker_core.sv -----
// ---------------------------------------------------------------------------
// percent_reversal_trend_tracker_core
// Three zigzag percent-reversal trackers over two moving-average samples.
//
// Channels: in_ch carries first_average and second_average (valid/ready);
// out_ch returns one result per item: the three directions (0 none, 1 up,
// 2 down) and all_decided. cfg_we/cfg_index/cfg_data write the thresholds
// (index 0 first, 1 second, 2 closer; other indexes are dropped).
// Path: an accepted item is written into the queue and waits at the queue
// head, where the tracker update reads it; the result is then loaded into
// the output register.
// Throughput: one item per cycle while out_ch.ready stays high, set by the
// tracker update whose extremes and direction feed back into the next item.
// Reset (synchronous, rst_n low): queue and output emptied, every tracker
// returns to none with high zero and low all ones, thresholds to 1.00 %.
// Receiver stall: the output register holds its item; the two-entry queue
// keeps taking input until full, then in_ch.ready drops.
// ---------------------------------------------------------------------------
`include "percent_reversal_trend_tracker_core_assert.svh"

module percent_reversal_trend_tracker_core
  import prt_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  prt_in_if.sink                  in_ch,
  prt_out_if.source               out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [THRESH_BITS-1:0]  cfg_data
);

  localparam int unsigned TRACKERS = 3;

  // Threshold registers, one per tracker.
  logic [THRESH_BITS-1:0] thresh_r [TRACKERS];

  // Queue head and the back-end handshake.
  queue_ctl_t             qctl;
  logic [SAMPLE_BITS-1:0] head_first, head_second;

  // Tracker directions: current and the value after this step.
  dir_t                   dir_cur [TRACKERS];
  dir_t                   dir_new [TRACKERS];

  // Output register.
  logic                   out_valid_r;
  logic                   all_decided_r;
  dir_t                   first_dir_r, second_dir_r, closer_dir_r;

  // Front end: accept and queue.
  prt_queue #(.SAMPLE_BITS(SAMPLE_BITS)) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .ctl_in      (qctl),
    .head_valid  (qctl.valid),
    .head_first  (head_first),
    .head_second (head_second)
  );

  // The back end takes the head item whenever the output register is free
  // or is being emptied in this same cycle.
  assign qctl.pop = qctl.valid && (!out_valid_r || out_ch.ready);

  // Tracker 0 follows the first sample; trackers 1 and 2 both follow the
  // second sample with their own thresholds.
  prt_tracker #(.SAMPLE_BITS(SAMPLE_BITS)) u_first (
    .clk (clk), .rst_n (rst_n), .step (qctl.pop), .sample (head_first),
    .threshold (thresh_r[0]), .dir (dir_cur[0]), .dir_nxt (dir_new[0])
  );

  prt_tracker #(.SAMPLE_BITS(SAMPLE_BITS)) u_second (
    .clk (clk), .rst_n (rst_n), .step (qctl.pop), .sample (head_second),
    .threshold (thresh_r[1]), .dir (dir_cur[1]), .dir_nxt (dir_new[1])
  );

  prt_tracker #(.SAMPLE_BITS(SAMPLE_BITS)) u_closer (
    .clk (clk), .rst_n (rst_n), .step (qctl.pop), .sample (head_second),
    .threshold (thresh_r[2]), .dir (dir_cur[2]), .dir_nxt (dir_new[2])
  );

  // Configuration writes only while the block is idle; user-enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r[0] <= THRESH_RESET;
      thresh_r[1] <= THRESH_RESET;
      thresh_r[2] <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_THRESHOLD:  thresh_r[0] <= cfg_data;
        CFG_SECOND_THRESHOLD: thresh_r[1] <= cfg_data;
        CFG_CLOSER_THRESHOLD: thresh_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register: loaded with the post-update directions on each step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (qctl.pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (qctl.pop) begin
      all_decided_r <= (dir_new[0] != DIR_NONE) && (dir_new[1] != DIR_NONE) &&
                       (dir_new[2] != DIR_NONE);
      first_dir_r   <= dir_new[0];
      second_dir_r  <= dir_new[1];
      closer_dir_r  <= dir_new[2];
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.all_decided      = all_decided_r;
  assign out_ch.first_direction  = first_dir_r;
  assign out_ch.second_direction = second_dir_r;
  assign out_ch.closer_direction = closer_dir_r;

  // A held result is never overwritten by a new step.
  `PRT_ASSERT_SAME(a_no_overwrite, clk, rst_n, out_valid_r && !out_ch.ready, !qctl.pop)

  // The summary bit agrees with the three directions it summarizes.
  `PRT_ASSERT_SAME(a_summary, clk, rst_n, out_valid_r,
    all_decided_r == ((first_dir_r != DIR_NONE) && (second_dir_r != DIR_NONE) &&
                      (closer_dir_r != DIR_NONE)))

  // Once a tracker has committed it never falls back to none.
  `PRT_ASSERT_NEXT(a_first_kept, clk, rst_n, dir_cur[0] != DIR_NONE, dir_cur[0] != DIR_NONE)
  `PRT_ASSERT_NEXT(a_second_kept, clk, rst_n, dir_cur[1] != DIR_NONE, dir_cur[1] != DIR_NONE)
  `PRT_ASSERT_NEXT(a_closer_kept, clk, rst_n, dir_cur[2] != DIR_NONE, dir_cur[2] != DIR_NONE)

endmodule

// ----- rtl/prt_queue.sv -----
// ---------------------------------------------------------------------------
// prt_queue
// Front end: accepts input items, cuts or zero-extends samples to the tracked width and
// holds them in a short queue for the tracker back end.
// ---------------------------------------------------------------------------
module prt_queue
  import prt_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  prt_in_if.sink                 in_ch,
  input  queue_ctl_t             ctl_in,
  output logic                   head_valid,
  output logic [SAMPLE_BITS-1:0] head_first,
  output logic [SAMPLE_BITS-1:0] head_second
);

  localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [SAMPLE_BITS-1:0] first_mem  [QUEUE_DEPTH];
  logic [SAMPLE_BITS-1:0] second_mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]    count_r, count_nxt;
  logic [SAMPLE_BITS-1:0] first_cut, second_cut;
  logic                   push;

  // Input bits above the tracked width are dropped; a wider tracked width
  // zero-extends the field.
  if (SAMPLE_BITS >= INPUT_BITS) begin : g_widen
    assign first_cut  = SAMPLE_BITS'(in_ch.first_average);
    assign second_cut = SAMPLE_BITS'(in_ch.second_average);
  end else begin : g_cut
    assign first_cut  = in_ch.first_average[SAMPLE_BITS-1:0];
    assign second_cut = in_ch.second_average[SAMPLE_BITS-1:0];
  end

  assign in_ch.ready = (count_r != CNT_BITS'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (count_r != '0);
  assign head_first  = first_mem[rd_ptr_r];
  assign head_second = second_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (ctl_in.pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !ctl_in.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && ctl_in.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      first_mem[wr_ptr_r]  <= first_cut;
      second_mem[wr_ptr_r] <= second_cut;
    end
  end

endmodule

// ----- rtl/prt_tracker.sv -----
// ---------------------------------------------------------------------------
// prt_tracker
// One zigzag tracker: running extremes, last extreme and direction, updated
// on each step with an exact cross-multiplied percent test.
// ---------------------------------------------------------------------------
module prt_tracker
  import prt_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [THRESH_BITS-1:0] threshold,
  output dir_t                   dir,
  output dir_t                   dir_nxt
);

  localparam int unsigned PROD_BITS = SAMPLE_BITS + 16;

  dir_t                   dir_r;
  logic [SAMPLE_BITS-1:0] high_r, high_nxt;
  logic [SAMPLE_BITS-1:0] low_r, low_nxt;
  logic                   high_last_r, high_last_nxt;
  logic [SAMPLE_BITS-1:0] hi_upd, lo_upd;
  logic                   hl_upd;
  logic [SAMPLE_BITS-1:0] excess, base;
  logic                   excess_ok;
  logic [PROD_BITS-1:0]   lhs, rhs;
  logic                   over;
  dir_t                   dir_calc;

  // Fold the sample into the running extremes first.
  always_comb begin
    hi_upd = high_r;
    lo_upd = low_r;
    hl_upd = high_last_r;
    if (sample > high_r) begin
      hi_upd = sample;
      hl_upd = 1'b1;
    end
    if (sample < low_r) begin
      lo_upd = sample;
      hl_upd = 1'b0;
    end
  end

  // One excess/base pair per direction feeds a single shared compare.
  always_comb begin
    unique case (dir_r)
      DIR_NONE: begin
        excess_ok = (hi_upd > lo_upd);
        excess    = hi_upd - lo_upd;
        base      = hl_upd ? lo_upd : hi_upd;
      end
      DIR_UP: begin
        excess_ok = (sample < hi_upd);
        excess    = hi_upd - sample;
        base      = hi_upd;
      end
      default: begin
        excess_ok = (sample > lo_upd);
        excess    = sample - lo_upd;
        base      = lo_upd;
      end
    endcase
  end

  assign lhs  = PROD_BITS'(excess) * PROD_BITS'(PCT_SCALE);
  assign rhs  = PROD_BITS'(threshold) * PROD_BITS'(base);
  assign over = excess_ok && (lhs > rhs);

  always_comb begin
    dir_calc      = dir_r;
    high_nxt      = hi_upd;
    low_nxt       = lo_upd;
    high_last_nxt = hl_upd;
    unique case (dir_r)
      DIR_NONE: begin
        if (over) begin
          dir_calc = hl_upd ? DIR_UP : DIR_DOWN;
        end
      end
      DIR_UP: begin
        if (over) begin
          dir_calc = DIR_DOWN;
          low_nxt  = sample;
        end
      end
      default: begin
        if (over) begin
          dir_calc = DIR_UP;
          high_nxt = sample;
        end
      end
    endcase
  end

  assign dir     = dir_r;
  assign dir_nxt = dir_calc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= DIR_NONE;
      high_r      <= '0;
      low_r       <= '1;
      high_last_r <= 1'b0;
    end else if (step) begin
      dir_r       <= dir_calc;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      high_last_r <= high_last_nxt;
    end
  end

endmodule
